// File: rtl/core/fss_pkg.sv
// shared types, constants and helpers for the fuzzy subsequence scorer
`timescale 1ns / 1ps

package fss_pkg;

    // configuration port geometry
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;
    localparam int LEN_W       = 5;

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 2'd2;

    // word boundary bytes
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CHAR_HYPHEN     = 8'h2D;

    // ascii folding range
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // score constants
    localparam logic [4:0] BOUNDARY_BONUS = 5'd2;
    localparam logic [3:0] RUN_MAX        = 4'd15;
    localparam logic [7:0] TOTAL_MAX      = 8'd255;

    // one candidate byte transfer
    typedef struct packed {
        logic [7:0] char_code;
        logic       has_char;
        logic       last;
    } in_item_t;

    // one result transfer
    typedef struct packed {
        logic       matched;
        logic [7:0] score;
    } out_item_t;

    // per-string scoring state, query position kept apart
    typedef struct packed {
        logic [3:0] run_length;
        logic [7:0] running_total;
        logic [7:0] previous_byte;
        logic       at_string_start;
    } score_state_t;

    localparam score_state_t STATE_RESET = '{
        run_length:      4'd0,
        running_total:   8'd0,
        previous_byte:   8'd0,
        at_string_start: 1'b1
    };

    // lower-case fold of 'A'..'Z' only
    function automatic logic [7:0] fold_case(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z)
        begin
            r = b + CASE_OFFSET;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/fss_if.sv
// valid/ready channel interfaces for candidate bytes and results
`timescale 1ns / 1ps

interface fss_in_if;
    logic               valid;
    logic               ready;
    fss_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface fss_out_if;
    logic               valid;
    logic               ready;
    fss_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/fss_query_regs.sv
// query byte registers, length register and query byte lookup
`timescale 1ns / 1ps

module fss_query_regs #(
    parameter int MAX_QUERY = 16,
    parameter int POS_W     = 5,
    parameter int IDX_W     = 4
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [fss_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fss_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [POS_W-1:0]                 query_pos,
    output logic [7:0]                       query_byte,
    output logic [POS_W-1:0]                 query_len
);

    localparam logic [fss_pkg::LEN_W-1:0] MAX_LEN = fss_pkg::LEN_W'(MAX_QUERY);

    logic [7:0]                query_reg [MAX_QUERY];
    logic [fss_pkg::LEN_W-1:0] length_reg;
    logic [IDX_W-1:0]          query_idx;

    // byte registers, low word feeds bytes 0..7, high word bytes 8..15
    for (genvar g = 0; g < MAX_QUERY; g++)
    begin : g_byte
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                query_reg[g] <= 8'd0;
            end
            else if (cfg_write)
            begin
                if (g < 8 && cfg_index == fss_pkg::CFG_PATTERN_LOW)
                begin
                    query_reg[g] <= cfg_data[(g % 8) * 8 +: 8];
                end
                else if (g >= 8 && cfg_index == fss_pkg::CFG_PATTERN_HIGH)
                begin
                    query_reg[g] <= cfg_data[(g % 8) * 8 +: 8];
                end
            end
        end
    end

    // length register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg <= '0;
        end
        else if (cfg_write && cfg_index == fss_pkg::CFG_PATTERN_LENGTH)
        begin
            length_reg <= cfg_data[fss_pkg::LEN_W-1:0];
        end
    end

    // length clamped to the query storage
    assign query_len = (length_reg > MAX_LEN) ? POS_W'(MAX_QUERY)
                                              : length_reg[POS_W-1:0];

    // byte at the current position, taken from its low index bits; zero for an index past the storage
    assign query_idx = query_pos[IDX_W-1:0];

    always_comb
    begin
        query_byte = 8'd0;
        if (32'(query_idx) < MAX_QUERY)
        begin
            query_byte = query_reg[query_idx];
        end
    end

endmodule

// File: rtl/core/fss_score_step.sv
// one-byte scoring step: match, run, bonus, saturation and string end
`timescale 1ns / 1ps

module fss_score_step #(
    parameter int POS_W = 5
) (
    input  fss_pkg::in_item_t      item,
    input  fss_pkg::score_state_t  state_cur,
    input  logic [POS_W-1:0]       pos_cur,
    input  logic [7:0]             query_byte,
    input  logic [POS_W-1:0]       query_len,
    output fss_pkg::score_state_t  state_new,
    output logic [POS_W-1:0]       pos_new,
    output fss_pkg::out_item_t     result
);

    fss_pkg::score_state_t st;
    logic [POS_W-1:0]      pos;
    logic                  boundary;
    logic                  hit;
    logic [4:0]            add;
    logic [8:0]            sum;
    logic                  matched;

    // greedy match against the query byte at the current position
    assign hit = fss_pkg::fold_case(query_byte) == fss_pkg::fold_case(item.char_code);

    assign boundary = state_cur.at_string_start
                   || state_cur.previous_byte == fss_pkg::CHAR_SPACE
                   || state_cur.previous_byte == fss_pkg::CHAR_UNDERSCORE
                   || state_cur.previous_byte == fss_pkg::CHAR_HYPHEN;

    assign add = 5'd1 + {1'b0, state_cur.run_length}
               + (boundary ? fss_pkg::BOUNDARY_BONUS : 5'd0);
    assign sum = {1'b0, state_cur.running_total} + {4'd0, add};

    // state after this byte
    always_comb
    begin
        st  = state_cur;
        pos = pos_cur;
        if (item.has_char)
        begin
            if (pos_cur < query_len)
            begin
                if (hit)
                begin
                    st.running_total = sum[8] ? fss_pkg::TOTAL_MAX : sum[7:0];
                    if (state_cur.run_length != fss_pkg::RUN_MAX)
                    begin
                        st.run_length = state_cur.run_length + 4'd1;
                    end
                    pos = pos_cur + POS_W'(1);
                end
                else
                begin
                    st.run_length = 4'd0;
                end
            end
            st.previous_byte   = item.char_code;
            st.at_string_start = 1'b0;
        end
    end

    // result and clear on the last byte of a string
    assign matched        = pos >= query_len;
    assign result.matched = matched;
    assign result.score   = matched ? st.running_total : 8'd0;
    assign state_new      = item.last ? fss_pkg::STATE_RESET : st;
    assign pos_new        = item.last ? '0 : pos;

endmodule

// File: rtl/core/fuzzy_subsequence_scorer_core.sv
// top level: input stage, string state, result register and query registers
`timescale 1ns / 1ps

// Scores one candidate string per run of byte transfers against a query of up
// to MAX_QUERY bytes, matching in order and ignoring ASCII case. The block
// takes one byte per clock while the input is not stalled; a byte enters an
// input register, is scored from there by the single compare-and-add loop on
// the string state, and the result of a string lands in an output register.
// Input stalls only while a finished result waits to be taken and the staged
// byte is another last byte. Configuration writes must be made only when no
// byte is in flight; the block itself does not enforce this. The query
// registers are read as they stand when each byte is scored.

module fuzzy_subsequence_scorer_core #(
    parameter int MAX_QUERY = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    fss_in_if.sink                           chars,
    fss_out_if.source                        results,
    input  logic                             cfg_write,
    input  logic [fss_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [fss_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int POS_W = $clog2(MAX_QUERY + 1);
    localparam int IDX_W = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;

    logic                  stage_valid_reg;
    logic                  stage_valid_next;
    fss_pkg::in_item_t     stage_item_reg;
    fss_pkg::score_state_t state_reg;
    fss_pkg::score_state_t state_next;
    logic [POS_W-1:0]      pos_reg;
    logic [POS_W-1:0]      pos_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    fss_pkg::out_item_t    out_item_reg;
    fss_pkg::out_item_t    step_result;
    logic [7:0]            query_byte;
    logic [POS_W-1:0]      query_len;
    logic                  advance;
    logic                  fire;
    logic                  accept;

    fss_query_regs #(
        .MAX_QUERY (MAX_QUERY),
        .POS_W     (POS_W),
        .IDX_W     (IDX_W)
    ) u_query_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .query_pos  (pos_reg),
        .query_byte (query_byte),
        .query_len  (query_len)
    );

    fss_score_step #(
        .POS_W (POS_W)
    ) u_score_step (
        .item       (stage_item_reg),
        .state_cur  (state_reg),
        .pos_cur    (pos_reg),
        .query_byte (query_byte),
        .query_len  (query_len),
        .state_new  (state_next),
        .pos_new    (pos_next),
        .result     (step_result)
    );

    // staged byte may be scored unless its result has nowhere to go
    assign advance = !stage_item_reg.last || !out_valid_reg || results.ready;
    assign fire    = stage_valid_reg && advance;
    assign chars.ready = !stage_valid_reg || advance;
    assign accept  = chars.valid && chars.ready;

    assign stage_valid_next = accept ? 1'b1 : (fire ? 1'b0 : stage_valid_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire && stage_item_reg.last)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_item_reg <= chars.data;
        end
    end

    // string state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= fss_pkg::STATE_RESET;
            pos_reg   <= '0;
        end
        else if (fire)
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (fire && stage_item_reg.last)
        begin
            out_item_reg <= step_result;
        end
    end

    assign results.valid = out_valid_reg;
    assign results.data  = out_item_reg;

endmodule

// File: rtl/core/fss_checker.sv
// port-level assertions for the scorer core and their bind
`timescale 1ns / 1ps

module fss_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               res_valid,
    input logic               res_ready,
    input fss_pkg::out_item_t res_data
);

    // a stalled result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // a failed match carries no score
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.matched |-> res_data.score == 8'd0)
        else $error("nonzero score on a failed match");

    // score stays within the reachable maximum
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_data.score <= 8'd168)
        else $error("score above reachable maximum");

    // input backpressure only while a result waits to be taken
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> res_valid && !res_ready)
        else $error("input stalled with free result register");

    // a stalled input side frees up once the result transfer happens
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready && res_ready |=> in_ready)
        else $error("input still stalled after result transfer");

endmodule

bind fuzzy_subsequence_scorer_core fss_checker u_fss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (chars.valid),
    .in_ready  (chars.ready),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res_data  (results.data)
);

// File: bench/fss_score_predictor.sv
// predicts the fuzzy subsequence score of each candidate string and checks every result
`timescale 1ns / 1ps

module fss_score_predictor (
    input  logic                            clk,
    input  logic                            rst_n,
    fss_in_if                               chars,
    fss_out_if                              results,
    input  logic                            cfg_write,
    input  logic [fss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [fss_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int unsigned                     mismatch_count,
    output int unsigned                     scores_waiting,
    output int unsigned                     strings_scored,
    output int unsigned                     strings_matched
);

    localparam int         QUERY_MAX       = 16;
    localparam logic [7:0] BYTE_SPACE      = 8'h20;
    localparam logic [7:0] BYTE_UNDERSCORE = 8'h5F;
    localparam logic [7:0] BYTE_HYPHEN     = 8'h2D;
    localparam logic [7:0] UPPER_FIRST     = 8'h41;
    localparam logic [7:0] UPPER_LAST      = 8'h5A;
    localparam logic [7:0] FOLD_OFFSET     = 8'h20;
    localparam int         WORD_BONUS      = 2;
    localparam logic [3:0] RUN_CAP         = 4'd15;
    localparam int         TOTAL_CAP       = 255;

    // mirrored query registers
    logic [127:0] query_bytes;
    logic [4:0]   query_len;

    // per-string match state
    logic [4:0]   query_pos;
    logic [3:0]   run_len;
    logic [7:0]   total;
    logic [7:0]   prev_char;
    logic         at_start;

    fss_pkg::out_item_t score_queue[$];
    fss_pkg::out_item_t oldest_score;
    int unsigned        fails;
    int unsigned        scored;
    int unsigned        full_matches;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= UPPER_FIRST && c <= UPPER_LAST)
        begin
            return c + FOLD_OFFSET;
        end
        return c;
    endfunction

    task automatic clear_string();
        query_pos = '0;
        run_len   = '0;
        total     = '0;
        prev_char = '0;
        at_start  = 1'b1;
    endtask

    // greedy match of one transfer; a last transfer queues the string verdict
    task automatic score_char(input fss_pkg::in_item_t item);
        logic [4:0]         limit;
        logic [7:0]         want;
        int                 gain;
        fss_pkg::out_item_t verdict;
        limit = (query_len > QUERY_MAX) ? 5'(QUERY_MAX) : query_len;
        if (item.has_char)
        begin
            if (query_pos < limit)
            begin
                want = query_bytes[query_pos[3:0]*8 +: 8];
                if (to_lower(want) == to_lower(item.char_code))
                begin
                    gain = 1 + int'(run_len);
                    if (at_start || prev_char == BYTE_SPACE ||
                        prev_char == BYTE_UNDERSCORE || prev_char == BYTE_HYPHEN)
                    begin
                        gain += WORD_BONUS;
                    end
                    total = (int'(total) + gain > TOTAL_CAP) ? 8'(TOTAL_CAP)
                                                            : 8'(int'(total) + gain);
                    if (run_len < RUN_CAP)
                    begin
                        run_len++;
                    end
                    query_pos++;
                end
                else
                begin
                    run_len = '0;
                end
            end
            prev_char = item.char_code;
            at_start  = 1'b0;
        end
        if (item.last)
        begin
            verdict.matched = (query_pos >= limit);
            verdict.score   = verdict.matched ? total : 8'd0;
            score_queue.push_back(verdict);
            clear_string();
        end
    endtask

    // config mirror, result compare, then prediction of the new transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_bytes = '0;
            query_len   = '0;
            clear_string();
            score_queue.delete();
            fails          = 0;
            scored         = 0;
            full_matches   = 0;
            mismatch_count <= 0;
            scores_waiting <= 0;
            strings_scored <= 0;
            strings_matched <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    fss_pkg::CFG_PATTERN_LOW:    query_bytes[63:0]   = cfg_data;
                    fss_pkg::CFG_PATTERN_HIGH:   query_bytes[127:64] = cfg_data;
                    fss_pkg::CFG_PATTERN_LENGTH: query_len           = cfg_data[4:0];
                    default:                     ;
                endcase
            end

            if (results.valid && results.ready)
            begin
                if (score_queue.size() == 0)
                begin
                    fails++;
                    $error("result with no string pending: matched %0b score %0d",
                           results.data.matched, results.data.score);
                end
                else
                begin
                    oldest_score = score_queue.pop_front();
                    scored++;
                    if (oldest_score.matched)
                    begin
                        full_matches++;
                    end
                    if (results.data.matched !== oldest_score.matched)
                    begin
                        fails++;
                        $error("matched: expected %0b, got %0b",
                               oldest_score.matched, results.data.matched);
                    end
                    if (results.data.score !== oldest_score.score)
                    begin
                        fails++;
                        $error("score: expected %0d, got %0d",
                               oldest_score.score, results.data.score);
                    end
                end
            end

            if (chars.valid && chars.ready)
            begin
                score_char(chars.data);
            end

            mismatch_count  <= fails;
            scores_waiting  <= score_queue.size();
            strings_scored  <= scored;
            strings_matched <= full_matches;
        end
    end

endmodule

// File: bench/tb.sv
// top of the scorer testbench: clock, reset, query setup, byte stimulus and verdict
`timescale 1ns / 1ps

module tb;

    localparam int         ITEM_TARGET   = 1350;
    localparam int         QUIET_LIMIT   = 2000;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         DRAIN_CYCLES  = 8;
    localparam int         QUERY_MAX     = 16;
    localparam logic [7:0] BYTE_SPACE      = 8'h20;
    localparam logic [7:0] BYTE_UNDERSCORE = 8'h5F;
    localparam logic [7:0] BYTE_HYPHEN     = 8'h2D;
    localparam logic [7:0] UPPER_A         = 8'h41;
    localparam logic [7:0] UPPER_Z         = 8'h5A;
    localparam logic [7:0] LOWER_A         = 8'h61;
    localparam logic [7:0] LOWER_Z         = 8'h7A;
    localparam logic [7:0] CASE_GAP        = 8'h20;

    typedef enum int {STALL_NONE, STALL_COIN, STALL_THIRDS, STALL_LONG} stall_mode_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_write;
    logic [fss_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [fss_pkg::CFG_DATA_W-1:0]  cfg_data;

    fss_in_if  chars_bus();
    fss_out_if results_bus();

    int unsigned mismatch_count;
    int unsigned scores_waiting;
    int unsigned strings_scored;
    int unsigned strings_matched;

    // sender state
    bit                 feeding;
    int                 burst_left;
    int                 gap_len;
    int                 chars_sent;
    int                 settings_used;
    int                 quiet_cycles;
    logic [7:0]         query_now[QUERY_MAX];
    int                 query_used;
    fss_pkg::in_item_t  cand[$];

    fuzzy_subsequence_scorer_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .chars     (chars_bus),
        .results   (results_bus),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    fss_score_predictor score_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .chars           (chars_bus),
        .results         (results_bus),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .mismatch_count  (mismatch_count),
        .scores_waiting  (scores_waiting),
        .strings_scored  (strings_scored),
        .strings_matched (strings_matched)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic fss_pkg::in_item_t make_item(input logic [7:0] c, input logic has,
                                                    input logic fin);
        fss_pkg::in_item_t it;
        it.char_code = c;
        it.has_char  = has;
        it.last      = fin;
        return it;
    endfunction

    // flip ascii letter case at random
    function automatic logic [7:0] shuffle_case(input logic [7:0] c);
        if (c >= LOWER_A && c <= LOWER_Z && $urandom_range(0, 1) == 1)
        begin
            return c - CASE_GAP;
        end
        if (c >= UPPER_A && c <= UPPER_Z && $urandom_range(0, 1) == 1)
        begin
            return c + CASE_GAP;
        end
        return c;
    endfunction

    function automatic logic [7:0] pick_boundary();
        case ($urandom_range(0, 2))
            0:       return BYTE_SPACE;
            1:       return BYTE_UNDERSCORE;
            default: return BYTE_HYPHEN;
        endcase
    endfunction

    // filler bytes lean on letters and word boundaries
    function automatic logic [7:0] pick_filler();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return shuffle_case(LOWER_A + 8'($urandom_range(0, 25)));
            4, 5:       return pick_boundary();
            default:    return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_query_char();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return shuffle_case(LOWER_A + 8'($urandom_range(0, 25)));
            6:                return pick_boundary();
            default:          return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // one byte transfer, sent in bursts with random gaps
    task automatic push_char(input fss_pkg::in_item_t item);
        if (!feeding)
        begin
            repeat (gap_len) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 8);
        end
        chars_bus.valid <= 1'b1;
        chars_bus.data  <= item;
        feeding = 1'b1;
        @(posedge clk);
        while (!chars_bus.ready) @(posedge clk);
        chars_sent++;
        burst_left--;
        if (burst_left == 0)
        begin
            chars_bus.valid <= 1'b0;
            feeding = 1'b0;
            gap_len = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 20)
                                                  : $urandom_range(1, 3);
        end
    endtask

    task automatic stop_chars();
        if (feeding)
        begin
            chars_bus.valid <= 1'b0;
            feeding    = 1'b0;
            burst_left = 0;
            gap_len    = 1;
        end
    endtask

    // hold until every pending score is back and the pipeline has emptied
    task automatic wait_idle();
        do @(posedge clk); while (scores_waiting != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [fss_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [fss_pkg::CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic load_query(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [fss_pkg::CFG_DATA_W-1:0] len_word);
        logic [127:0] both;
        stop_chars();
        wait_idle();
        write_reg(fss_pkg::CFG_PATTERN_LOW, lo);
        write_reg(fss_pkg::CFG_PATTERN_HIGH, hi);
        write_reg(fss_pkg::CFG_PATTERN_LENGTH, len_word);
        cfg_write <= 1'b0;
        both = {hi, lo};
        for (int i = 0; i < QUERY_MAX; i++)
        begin
            query_now[i] = both[i*8 +: 8];
        end
        query_used = (int'(len_word[4:0]) > QUERY_MAX) ? QUERY_MAX : int'(len_word[4:0]);
        settings_used++;
    endtask

    // candidate byte, sometimes preceded by a transfer with no byte
    task automatic add_char(input logic [7:0] c);
        if ($urandom_range(0, 11) == 0)
        begin
            cand.push_back(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
        end
        cand.push_back(make_item(c, 1'b1, 1'b0));
    endtask

    task automatic send_cand();
        if (cand.size() == 0 || $urandom_range(0, 7) == 0)
        begin
            cand.push_back(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
        end
        else
        begin
            cand[cand.size()-1].last = 1'b1;
        end
        foreach (cand[i])
        begin
            push_char(cand[i]);
        end
        cand.delete();
    endtask

    // result ready follows a pattern of its own, switching mode now and then
    initial
    begin : result_stall
        stall_mode_t mode;
        int          mode_left;
        int          tick;
        results_bus.ready = 1'b0;
        mode      = STALL_NONE;
        mode_left = 0;
        tick      = 0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode      = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            tick++;
            case (mode)
                STALL_NONE:   results_bus.ready <= 1'b1;
                STALL_COIN:   results_bus.ready <= 1'($urandom_range(0, 1));
                STALL_THIRDS: results_bus.ready <= (tick % 3 == 0);
                default:      results_bus.ready <= (tick % 10 == 0);
            endcase
        end
    end

    // end the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (chars_bus.valid && chars_bus.ready) ||
            (results_bus.valid && results_bus.ready))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [63:0]                    lo;
        logic [63:0]                    hi;
        logic [fss_pkg::CFG_DATA_W-1:0] len_word;
        int                             phase;
        int                             strings_left;

        rst_n           = 1'b0;
        cfg_write       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        chars_bus.valid = 1'b0;
        chars_bus.data  = '0;
        feeding         = 1'b0;
        burst_left      = 0;
        gap_len         = 1;
        chars_sent      = 0;
        settings_used   = 0;
        query_used      = 0;
        phase           = 0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // empty query out of reset: everything matches with score zero
        push_char(make_item(8'h00, 1'b1, 1'b1));
        // empty string end with no byte at all
        push_char(make_item(8'hA5, 1'b0, 1'b1));

        // query "aZ", a zero byte, then a high byte that must not fold
        load_query({32'h0, 8'hC8, 8'h00, UPPER_Z, LOWER_A}, 64'h0, 64'd4);
        // start bonus, case folding, hyphen bonus, run growth
        push_char(make_item(UPPER_A, 1'b1, 1'b0));
        push_char(make_item(BYTE_HYPHEN, 1'b1, 1'b0));
        push_char(make_item(LOWER_Z, 1'b1, 1'b0));
        push_char(make_item(8'h00, 1'b1, 1'b0));
        push_char(make_item(8'hC8, 1'b1, 1'b1));
        // byte-less transfer mid-string, and 0xe8 is not the lower case of 0xc8
        push_char(make_item(LOWER_A, 1'b1, 1'b0));
        push_char(make_item(LOWER_Z, 1'b1, 1'b0));
        push_char(make_item(8'h00, 1'b1, 1'b0));
        push_char(make_item(8'hFF, 1'b0, 1'b0));
        push_char(make_item(8'hE8, 1'b1, 1'b1));
        // bytes after the whole query is consumed are dropped
        push_char(make_item(LOWER_A, 1'b1, 1'b0));
        push_char(make_item(UPPER_Z, 1'b1, 1'b0));
        push_char(make_item(8'h00, 1'b1, 1'b0));
        push_char(make_item(8'hC8, 1'b1, 1'b0));
        push_char(make_item(BYTE_UNDERSCORE, 1'b1, 1'b1));
        // shorten the query while a string is half scored
        push_char(make_item(LOWER_A, 1'b1, 1'b0));
        stop_chars();
        wait_idle();
        write_reg(fss_pkg::CFG_PATTERN_LENGTH, 64'd1);
        cfg_write <= 1'b0;
        query_used = 1;
        push_char(make_item(8'h78, 1'b1, 1'b1));

        // random phases, each with its own query setting
        while (chars_sent < ITEM_TARGET)
        begin
            phase++;
            case (phase % 6)
                0:       len_word = 64'd16;
                1:       len_word = 64'd31;
                2:       len_word = 64'd0;
                3:       len_word = 64'd1;
                default: len_word = 64'($urandom_range(0, 31));
            endcase
            if ($urandom_range(0, 1) == 1)
            begin
                len_word[63:5] = 59'({$urandom, $urandom});
            end
            case (phase % 7)
                0:
                begin
                    lo = '1;
                    hi = '1;
                end
                1:
                begin
                    lo = '0;
                    hi = '0;
                end
                default:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        lo[i*8 +: 8] = pick_query_char();
                        hi[i*8 +: 8] = pick_query_char();
                    end
                end
            endcase
            load_query(lo, hi, len_word);

            strings_left = $urandom_range(4, 12);
            while (strings_left > 0 && chars_sent < ITEM_TARGET)
            begin
                strings_left--;
                if ($urandom_range(0, 3) != 0)
                begin
                    // mostly the query in order, with filler and the odd dropped byte
                    for (int i = 0; i < query_used; i++)
                    begin
                        if ($urandom_range(0, 9) >= 6)
                        begin
                            repeat ($urandom_range(1, 3)) add_char(pick_filler());
                        end
                        if ($urandom_range(0, 19) != 0)
                        begin
                            add_char(shuffle_case(query_now[i]));
                        end
                    end
                    repeat ($urandom_range(0, 3)) add_char(pick_filler());
                end
                else
                begin
                    repeat ($urandom_range(0, 12)) add_char(pick_filler());
                end
                send_cand();
            end
        end

        stop_chars();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("scored %0d strings (%0d full matches) from %0d byte transfers",
                 strings_scored, strings_matched, chars_sent);
        $display("%0d query settings, lengths from empty up to past the 16-byte cap",
                 settings_used);
        if (mismatch_count == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/fss_pkg.sv
rtl/core/fss_if.sv
rtl/core/fss_query_regs.sv
rtl/core/fss_score_step.sv
rtl/core/fuzzy_subsequence_scorer_core.sv
rtl/core/fss_checker.sv
bench/fss_score_predictor.sv
bench/tb.sv
